@@ hdl/moving_average_crossover_defines.svh @@
// Assertion macros for the moving average crossover detector.
// Included by the port checker; depends on nothing else.
`ifndef MOVING_AVERAGE_CROSSOVER_DEFINES_SVH
`define MOVING_AVERAGE_CROSSOVER_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define MAC_ASSERT_SAME(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Property that must hold in the cycle after its trigger.
`define MAC_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

@@ hdl/mac_pkg.sv @@
// Shared constants for the moving average crossover detector.
// Used by the divider, the top level and the port checker; no dependencies.
package mac_pkg;

   // Field widths of one request and one response.
   localparam int SAMPLE_W = 24;
   localparam int WINDOW_W = 7;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 104;

   // Default ring depth and register reset values.
   localparam int MAX_WINDOW_DEF = 64;
   localparam logic [WINDOW_W-1:0] SHORT_WINDOW_RST = 7'd5;
   localparam logic [WINDOW_W-1:0] LONG_WINDOW_RST = 7'd25;

   // Quotient bits the divider retires per cycle.
   localparam int DIV_BITS = 2;

   // Flag positions in the response data, above the four averages.
   localparam int RSP_READY_BIT = 96;
   localparam int RSP_SMA_GOLDEN_BIT = 97;
   localparam int RSP_SMA_DEAD_BIT = 98;
   localparam int RSP_WMA_GOLDEN_BIT = 99;
   localparam int RSP_WMA_DEAD_BIT = 100;

endpackage

@@ hdl/moving_average_crossover.sv @@
// Moving average crossover detector, top level.
// Depends on mac_pkg, mac_ram (history ring) and mac_div (shared divider).
//
// Usage: one signed Q15.8 sample per request on req_*, one response per request
// on rsp_* with the short and long simple and weighted averages, a ready flag
// and golden/dead cross flags for both pairs. The user must write the window
// registers on csr_* only between requests; the block does not enforce it.
// Index 0 is the short window, index 1 the long one. Timing: a request is
// taken only when the block is idle. The ring is scanned with one memory
// read per cycle over the larger effective window wmax, then the sums are
// cross-multiplied and compared, and four divisions run one after another
// on the shared divider. No new request is taken until the response
// register has been loaded from the done state and the block is idle again.
// Reset: the ring is treated as all zeros through the fill count, the windows
// return to 5 and 25, and the stored relations to equal. Reset takes no
// clearing pass; a request may follow at once.
// Stall: a finished response waits in the output register while the next
// request is already accepted and processed; the block then holds its next
// response until rsp_tready frees the register.
module moving_average_crossover #(
   parameter int MAX_WINDOW = mac_pkg::MAX_WINDOW_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request: sample [23:0].
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mac_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Response: short_sma [23:0], long_sma [47:24], short_wma [71:48],
   // long_wma [95:72], averages_ready [96], sma_golden [97], sma_dead [98],
   // wma_golden [99], wma_dead [100], zero padding [103:101].
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mac_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Register writes.
   input  logic                              csr_we,
   input  logic [0:0]                        csr_index,
   input  logic [mac_pkg::WINDOW_W-1:0]      csr_wdata
);

   localparam int SW = mac_pkg::SAMPLE_W;
   localparam int REG_W = mac_pkg::WINDOW_W;
   localparam int AW = $clog2(MAX_WINDOW);
   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int DW = $clog2(MAX_WINDOW * (MAX_WINDOW + 1) / 2 + 1);
   localparam int EW = (CW > REG_W) ? CW : REG_W;
   localparam int PSUM_W = SW + CW;
   localparam int WSUM_W = SW + DW;
   localparam int SPROD_W = PSUM_W + CW + 1;
   localparam int WPROD_W = WSUM_W + DW + 1;

   localparam logic [0:0] CSR_SHORT_WINDOW = 1'b0;
   localparam logic [0:0] CSR_LONG_WINDOW = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_SCAN = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_CMP  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   typedef enum logic [1:0] {
      REL_EQ = 2'd0,
      REL_LT = 2'd1,
      REL_GT = 2'd2
   } rel_type;

   typedef enum logic [1:0] {
      SEL_SHORT_SMA = 2'd0,
      SEL_LONG_SMA  = 2'd1,
      SEL_SHORT_WMA = 2'd2,
      SEL_LONG_WMA  = 2'd3
   } avg_sel_type;

   state_type                 state_ff, state_in;
   logic [REG_W-1:0]          short_window_ff, short_window_in;
   logic [REG_W-1:0]          long_window_ff, long_window_in;
   logic [AW-1:0]             wp_ff, wp_in;
   logic [AW-1:0]             rp_ff, rp_in;
   logic [CW-1:0]             fill_ff, fill_in;
   logic [CW-1:0]             iss_k_ff, iss_k_in;
   logic                      iss_on_ff, iss_on_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [CW-1:0]             rd_k_ff, rd_k_in;
   logic signed [PSUM_W-1:0]  sp_s_ff, sp_s_in;
   logic signed [PSUM_W-1:0]  sp_l_ff, sp_l_in;
   logic signed [WSUM_W-1:0]  sw_s_ff, sw_s_in;
   logic signed [WSUM_W-1:0]  sw_l_ff, sw_l_in;
   logic [DW-1:0]             ds_ff, ds_in;
   logic [DW-1:0]             dl_ff, dl_in;
   logic                      prev_full_ff, prev_full_in;
   logic                      ready_ff, ready_in;
   rel_type                   sma_prev_ff, sma_prev_in;
   rel_type                   wma_prev_ff, wma_prev_in;
   logic signed [SPROD_W-1:0] sma_lhs_ff, sma_lhs_in;
   logic signed [SPROD_W-1:0] sma_rhs_ff, sma_rhs_in;
   logic signed [WPROD_W-1:0] wma_lhs_ff, wma_lhs_in;
   logic signed [WPROD_W-1:0] wma_rhs_ff, wma_rhs_in;
   logic                      sma_golden_ff, sma_golden_in;
   logic                      sma_dead_ff, sma_dead_in;
   logic                      wma_golden_ff, wma_golden_in;
   logic                      wma_dead_ff, wma_dead_in;
   avg_sel_type               div_sel_ff, div_sel_in;
   logic [SW-1:0]             avg_ff [4];
   logic [SW-1:0]             avg_in [4];
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [mac_pkg::RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   logic [CW-1:0]             ws_e, wl_e, wmax, wmax_m1;
   logic [CW-1:0]             fill_next;
   logic                      accept;
   logic                      ring_we, ring_re;
   logic [SW-1:0]             ring_q;
   logic signed [SW-1:0]      samp_v;
   rel_type                   sma_rel_c, wma_rel_c;
   logic                      div_start, div_done;
   avg_sel_type               div_idx;
   logic signed [WSUM_W-1:0]  div_dividend;
   logic [DW-1:0]             div_divisor;
   logic [SW-1:0]             div_quo;

   // A window of zero acts as one, one beyond the ring acts as the ring depth.
   function automatic logic [CW-1:0] eff_window(input logic [REG_W-1:0] w);
      logic [EW-1:0] wide;
      wide = EW'(w);
      if (w == '0) begin
         return CW'(1);
      end
      if (wide > EW'(MAX_WINDOW)) begin
         return CW'(MAX_WINDOW);
      end
      return wide[CW-1:0];
   endfunction

   assign ws_e = eff_window(short_window_ff);
   assign wl_e = eff_window(long_window_ff);
   assign wmax = (ws_e > wl_e) ? ws_e : wl_e;
   assign wmax_m1 = wmax - 1'b1;
   assign fill_next = (fill_ff == CW'(MAX_WINDOW)) ? fill_ff : fill_ff + 1'b1;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept = req_tvalid && req_tready;
   assign ring_we = accept;
   assign ring_re = (state_ff == ST_SCAN) && iss_on_ff;

   // History ring: written at acceptance, read back newest first.
   mac_ram #(
      .WIDTH(SW),
      .DEPTH(MAX_WINDOW)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ring_we),
      .wr_addr(wp_ff),
      .wr_data(req_tdata[SW-1:0]),
      .rd_en  (ring_re),
      .rd_addr(rp_ff),
      .rd_data(ring_q)
   );

   // Entries older than the fill count were never written and count as zero.
   assign samp_v = (rd_k_ff < fill_ff) ? signed'(ring_q) : '0;

   // Exact relation of the short average to the long one.
   always_comb begin
      if (sma_lhs_ff < sma_rhs_ff) begin
         sma_rel_c = REL_LT;
      end else if (sma_lhs_ff > sma_rhs_ff) begin
         sma_rel_c = REL_GT;
      end else begin
         sma_rel_c = REL_EQ;
      end
      if (wma_lhs_ff < wma_rhs_ff) begin
         wma_rel_c = REL_LT;
      end else if (wma_lhs_ff > wma_rhs_ff) begin
         wma_rel_c = REL_GT;
      end else begin
         wma_rel_c = REL_EQ;
      end
   end

   // Divider feed: the first division starts from the compare state, each
   // later one as soon as the previous quotient comes back.
   assign div_start = (state_ff == ST_CMP) ||
                      ((state_ff == ST_DIV) && div_done && (div_sel_ff != SEL_LONG_WMA));
   assign div_idx = (state_ff == ST_CMP) ? SEL_SHORT_SMA : avg_sel_type'(div_sel_ff + 2'd1);

   always_comb begin
      case (div_idx)
         SEL_SHORT_SMA: begin
            div_dividend = WSUM_W'(sp_s_ff);
            div_divisor = DW'(ws_e);
         end
         SEL_LONG_SMA: begin
            div_dividend = WSUM_W'(sp_l_ff);
            div_divisor = DW'(wl_e);
         end
         SEL_SHORT_WMA: begin
            div_dividend = sw_s_ff;
            div_divisor = ds_ff;
         end
         SEL_LONG_WMA: begin
            div_dividend = sw_l_ff;
            div_divisor = dl_ff;
         end
         default: begin
            div_dividend = '0;
            div_divisor = DW'(1);
         end
      endcase
   end

   mac_div #(
      .DVS_W(DW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quo)
   );

   // Register writes.
   always_comb begin
      short_window_in = short_window_ff;
      long_window_in = long_window_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SHORT_WINDOW: short_window_in = csr_wdata;
            CSR_LONG_WINDOW: long_window_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: accept, scan the ring, cross-multiply, compare, divide, respond.
   always_comb begin
      state_in = state_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      fill_in = fill_ff;
      iss_k_in = iss_k_ff;
      iss_on_in = iss_on_ff;
      rd_valid_in = ring_re;
      rd_k_in = iss_k_ff;
      sp_s_in = sp_s_ff;
      sp_l_in = sp_l_ff;
      sw_s_in = sw_s_ff;
      sw_l_in = sw_l_ff;
      ds_in = ds_ff;
      dl_in = dl_ff;
      prev_full_in = prev_full_ff;
      ready_in = ready_ff;
      sma_prev_in = sma_prev_ff;
      wma_prev_in = wma_prev_ff;
      sma_lhs_in = sma_lhs_ff;
      sma_rhs_in = sma_rhs_ff;
      wma_lhs_in = wma_lhs_ff;
      wma_rhs_in = wma_rhs_ff;
      sma_golden_in = sma_golden_ff;
      sma_dead_in = sma_dead_ff;
      wma_golden_in = wma_golden_ff;
      wma_dead_in = wma_dead_ff;
      div_sel_in = div_sel_ff;
      avg_in = avg_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in = rsp_tdata_ff;

      // The receiver frees the response register.
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wp_in = (wp_ff == AW'(MAX_WINDOW - 1)) ? '0 : wp_ff + 1'b1;
               rp_in = wp_ff;
               fill_in = fill_next;
               prev_full_in = (fill_ff >= wmax);
               ready_in = (fill_next >= wmax);
               iss_k_in = '0;
               iss_on_in = 1'b1;
               sp_s_in = '0;
               sp_l_in = '0;
               sw_s_in = '0;
               sw_l_in = '0;
               ds_in = '0;
               dl_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle, walking back from the newest entry.
            if (iss_on_ff) begin
               rp_in = (rp_ff == '0) ? AW'(MAX_WINDOW - 1) : rp_ff - 1'b1;
               iss_k_in = iss_k_ff + 1'b1;
               if (iss_k_ff == wmax_m1) begin
                  iss_on_in = 1'b0;
               end
            end
            // Weighted sum as the sum of the running plain sums, and the
            // weight total as 1 + 2 + ... + w.
            if (rd_valid_ff) begin
               if (rd_k_ff < ws_e) begin
                  sp_s_in = sp_s_ff + PSUM_W'(samp_v);
                  sw_s_in = sw_s_ff + WSUM_W'(sp_s_in);
                  ds_in = ds_ff + DW'(rd_k_ff) + DW'(1);
               end
               if (rd_k_ff < wl_e) begin
                  sp_l_in = sp_l_ff + PSUM_W'(samp_v);
                  sw_l_in = sw_l_ff + WSUM_W'(sp_l_in);
                  dl_in = dl_ff + DW'(rd_k_ff) + DW'(1);
               end
               if (rd_k_ff == wmax_m1) begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            sma_lhs_in = sp_s_ff * $signed({1'b0, wl_e});
            sma_rhs_in = sp_l_ff * $signed({1'b0, ws_e});
            wma_lhs_in = sw_s_ff * $signed({1'b0, dl_ff});
            wma_rhs_in = sw_l_ff * $signed({1'b0, ds_ff});
            state_in = ST_CMP;
         end
         ST_CMP: begin
            sma_golden_in = prev_full_ff && (sma_prev_ff == REL_LT) && (sma_rel_c == REL_GT);
            sma_dead_in = prev_full_ff && (sma_prev_ff == REL_GT) && (sma_rel_c == REL_LT);
            wma_golden_in = prev_full_ff && (wma_prev_ff == REL_LT) && (wma_rel_c == REL_GT);
            wma_dead_in = prev_full_ff && (wma_prev_ff == REL_GT) && (wma_rel_c == REL_LT);
            sma_prev_in = sma_rel_c;
            wma_prev_in = wma_rel_c;
            div_sel_in = SEL_SHORT_SMA;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in[div_sel_ff] = div_quo;
               if (div_sel_ff == SEL_LONG_WMA) begin
                  state_in = ST_DONE;
               end else begin
                  div_sel_in = div_idx;
               end
            end
         end
         ST_DONE: begin
            // Hand the result over once the response register is free.
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in = {3'b000, wma_dead_ff, wma_golden_ff, sma_dead_ff,
                               sma_golden_ff, ready_ff, avg_ff[SEL_LONG_WMA],
                               avg_ff[SEL_SHORT_WMA], avg_ff[SEL_LONG_SMA],
                               avg_ff[SEL_SHORT_SMA]};
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         short_window_ff <= mac_pkg::SHORT_WINDOW_RST;
         long_window_ff <= mac_pkg::LONG_WINDOW_RST;
         wp_ff <= '0;
         fill_ff <= '0;
         iss_on_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
         sma_prev_ff <= REL_EQ;
         wma_prev_ff <= REL_EQ;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         short_window_ff <= short_window_in;
         long_window_ff <= long_window_in;
         wp_ff <= wp_in;
         fill_ff <= fill_in;
         iss_on_ff <= iss_on_in;
         rd_valid_ff <= rd_valid_in;
         sma_prev_ff <= sma_prev_in;
         wma_prev_ff <= wma_prev_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rp_ff <= rp_in;
      iss_k_ff <= iss_k_in;
      rd_k_ff <= rd_k_in;
      sp_s_ff <= sp_s_in;
      sp_l_ff <= sp_l_in;
      sw_s_ff <= sw_s_in;
      sw_l_ff <= sw_l_in;
      ds_ff <= ds_in;
      dl_ff <= dl_in;
      prev_full_ff <= prev_full_in;
      ready_ff <= ready_in;
      sma_lhs_ff <= sma_lhs_in;
      sma_rhs_ff <= sma_rhs_in;
      wma_lhs_ff <= wma_lhs_in;
      wma_rhs_ff <= wma_rhs_in;
      sma_golden_ff <= sma_golden_in;
      sma_dead_ff <= sma_dead_in;
      wma_golden_ff <= wma_golden_in;
      wma_dead_ff <= wma_dead_in;
      div_sel_ff <= div_sel_in;
      avg_ff <= avg_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

endmodule

@@ hdl/mac_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; used for the sample history ring.
module mac_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mac_div.sv @@
// Iterative signed divider, truncating toward zero, two quotient bits per cycle.
// Depends on mac_pkg for the quotient width and the bits retired per cycle.
module mac_div #(
   parameter int DVS_W = 12
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic signed [mac_pkg::SAMPLE_W+DVS_W-1:0]   dividend,
   input  logic [DVS_W-1:0]                            divisor,
   output logic                                        done,
   output logic [mac_pkg::SAMPLE_W-1:0]                quotient
);

   localparam int QW = mac_pkg::SAMPLE_W;
   localparam int DVD_W = QW + DVS_W;
   localparam int RB = mac_pkg::DIV_BITS;
   localparam int STEPS = QW / RB;
   localparam int CNT_W = $clog2(STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [QW-1:0]    low_ff, low_in;
   logic [QW-1:0]    quo_ff, quo_in;

   logic [DVD_W-1:0] mag_c;
   logic [DVS_W-1:0] rem_v;
   logic [QW-1:0]    low_v;
   logic [DVS_W:0]   trial;

   // Magnitude of the dividend; the divisor is always positive.
   always_comb begin
      if (dividend[DVD_W-1]) begin
         mag_c = DVD_W'(~dividend + 1'b1);
      end else begin
         mag_c = DVD_W'(dividend);
      end
   end

   // Restoring steps: the remainder stays below the divisor, and the low
   // register shifts dividend bits out at the top and quotient bits in.
   always_comb begin
      rem_v = rem_ff;
      low_v = low_ff;
      trial = '0;
      for (int i = 0; i < RB; i++) begin
         trial = {rem_v, low_v[QW-1]};
         low_v = {low_v[QW-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_v = DVS_W'(trial - {1'b0, dvs_ff});
            low_v[0] = 1'b1;
         end else begin
            rem_v = trial[DVS_W-1:0];
         end
      end
   end

   // Sequencing of one division.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      dvs_in = dvs_ff;
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in = '0;
         neg_in = dividend[DVD_W-1];
         dvs_in = divisor;
         rem_in = mag_c[DVD_W-1:QW];
         low_in = mag_c[QW-1:0];
      end else if (busy_ff) begin
         rem_in = rem_v;
         low_in = low_v;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in = neg_ff ? QW'(~low_v + 1'b1) : low_v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/mac_checker.sv @@
// Port-level checks for the moving average crossover detector, bound to the top.
// Depends on mac_pkg and the assertion macros in the defines header.
`include "moving_average_crossover_defines.svh"

module mac_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [mac_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // Requests are processed one at a time; none is accepted back to back.
   `MAC_ASSERT_NEXT(a_req_one_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted back to back")

   // A stalled response keeps its data.
   `MAC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // A cross needs full windows and has one direction only.
   `MAC_ASSERT_SAME(a_cross_needs_ready, clock, reset, rsp_tvalid && (rsp_tdata[mac_pkg::RSP_SMA_GOLDEN_BIT] || rsp_tdata[mac_pkg::RSP_SMA_DEAD_BIT] || rsp_tdata[mac_pkg::RSP_WMA_GOLDEN_BIT] || rsp_tdata[mac_pkg::RSP_WMA_DEAD_BIT]), rsp_tdata[mac_pkg::RSP_READY_BIT] && !(rsp_tdata[mac_pkg::RSP_SMA_GOLDEN_BIT] && rsp_tdata[mac_pkg::RSP_SMA_DEAD_BIT]) && !(rsp_tdata[mac_pkg::RSP_WMA_GOLDEN_BIT] && rsp_tdata[mac_pkg::RSP_WMA_DEAD_BIT]), "cross flags inconsistent")

   // Leaving reset, the block is idle with no response pending.
   `MAC_ASSERT_SAME(a_reset_idle, clock, reset, $past(reset), req_tready && !rsp_tvalid, "not idle after reset")

endmodule

bind moving_average_crossover mac_checker u_mac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

@@ bench/testbench.sv @@
// Self-checking testbench for the moving average crossover detector.
// Predicts every response in the bench itself and compares it field by field.
// Depends on mac_pkg and the moving_average_crossover top level.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import mac_pkg::*;

   localparam int RING_DEPTH = MAX_WINDOW_DEF;
   localparam logic [0:0] SHORT_WINDOW_IDX = 1'b0;
   localparam logic [0:0] LONG_WINDOW_IDX = 1'b1;
   localparam int HOLD_OFF_CYCLES = 500;
   localparam int SETTLE_CYCLES = 130;

   typedef logic signed [SAMPLE_W-1:0] sample_t;
   typedef enum logic [1:0] {REL_EQUAL, REL_LESS, REL_GREATER} relation_t;

   typedef struct {
      logic [23:0] short_sma;
      logic [23:0] long_sma;
      logic [23:0] short_wma;
      logic [23:0] long_wma;
      logic        ready;
      logic        sma_golden;
      logic        sma_dead;
      logic        wma_golden;
      logic        wma_dead;
   } crossover_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [0:0]            csr_index = SHORT_WINDOW_IDX;
   logic [WINDOW_W-1:0]   csr_wdata = '0;

   // Predicted copy of the block's state and window registers.
   // The history starts cleared, as the block treats unwritten ring entries as zero.
   sample_t             history [RING_DEPTH] = '{default: '0};
   int                  history_head = 0;
   int                  history_fill = 0;
   relation_t           last_sma_relation = REL_EQUAL;
   relation_t           last_wma_relation = REL_EQUAL;
   logic [WINDOW_W-1:0] short_window_reg = SHORT_WINDOW_RST;
   logic [WINDOW_W-1:0] long_window_reg = LONG_WINDOW_RST;

   crossover_result_t expected_averages [$];
   int error_count = 0;
   int responses_checked = 0;
   int sma_crosses = 0;
   int wma_crosses = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_requests = 0;
   int hold_off_taken = 0;
   int hold_off_left = 0;

   moving_average_crossover u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // A register value of zero acts as one, anything above the ring depth as the depth.
   function automatic int effective_window(logic [WINDOW_W-1:0] value);
      if (value == 0) return 1;
      if (int'(value) > RING_DEPTH) return RING_DEPTH;
      return int'(value);
   endfunction

   // Plain and weighted sums over the newest samples; the newest gets the top weight.
   function automatic void window_sums(input int newest, input int width,
                                       output longint plain, output longint weighted);
      int idx;
      plain = 0;
      weighted = 0;
      for (int k = 0; k < width; k++) begin
         idx = (newest + RING_DEPTH - k) % RING_DEPTH;
         plain += longint'(history[idx]);
         weighted += longint'(history[idx]) * longint'(width - k);
      end
   endfunction

   // Exact comparison of two ratios with positive divisors.
   function automatic relation_t compare_ratios(longint num_a, longint den_a,
                                                longint num_b, longint den_b);
      longint lhs;
      longint rhs;
      lhs = num_a * den_b;
      rhs = num_b * den_a;
      if (lhs < rhs) return REL_LESS;
      if (lhs > rhs) return REL_GREATER;
      return REL_EQUAL;
   endfunction

   // Push one sample into the predicted history and work out the response.
   function automatic crossover_result_t predict_averages(sample_t sample);
      crossover_result_t r;
      longint ws;
      longint wl;
      longint short_den;
      longint long_den;
      longint short_sum;
      longint long_sum;
      longint short_wsum;
      longint long_wsum;
      int wmax;
      bit was_full;
      int newest;
      relation_t sma_now;
      relation_t wma_now;
      ws = effective_window(short_window_reg);
      wl = effective_window(long_window_reg);
      wmax = (ws > wl) ? int'(ws) : int'(wl);
      was_full = history_fill >= wmax;
      short_den = ws * (ws + 1) / 2;
      long_den = wl * (wl + 1) / 2;
      newest = history_head;
      history[newest] = sample;
      history_head = (newest + 1) % RING_DEPTH;
      if (history_fill < RING_DEPTH) history_fill++;
      window_sums(newest, int'(ws), short_sum, short_wsum);
      window_sums(newest, int'(wl), long_sum, long_wsum);
      sma_now = compare_ratios(short_sum, ws, long_sum, wl);
      wma_now = compare_ratios(short_wsum, short_den, long_wsum, long_den);
      r.short_sma = 24'(short_sum / ws);
      r.long_sma = 24'(long_sum / wl);
      r.short_wma = 24'(short_wsum / short_den);
      r.long_wma = 24'(long_wsum / long_den);
      r.ready = history_fill >= wmax;
      r.sma_golden = was_full && last_sma_relation == REL_LESS && sma_now == REL_GREATER;
      r.sma_dead = was_full && last_sma_relation == REL_GREATER && sma_now == REL_LESS;
      r.wma_golden = was_full && last_wma_relation == REL_LESS && wma_now == REL_GREATER;
      r.wma_dead = was_full && last_wma_relation == REL_GREATER && wma_now == REL_LESS;
      last_sma_relation = sma_now;
      last_wma_relation = wma_now;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [23:0] expected_value,
                                  logic [23:0] actual_value);
      error_count++;
      $display("ERROR %0t: response %0d field %s expected %h got %h", $realtime,
               responses_checked, field, expected_value, actual_value);
   endtask

   task automatic check_field(string field, logic [23:0] expected_value,
                              logic [23:0] actual_value);
      if (expected_value !== actual_value) report_mismatch(field, expected_value, actual_value);
   endtask

   // Offer one sample, wait for the handshake and record the predicted response.
   task automatic send_sample(sample_t sample);
      crossover_result_t r;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 150 : 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      do @(posedge clock); while (!req_tready);
      r = predict_averages(sample);
      if (r.sma_golden || r.sma_dead) sma_crosses++;
      if (r.wma_golden || r.wma_dead) wma_crosses++;
      expected_averages.push_back(r);
   endtask

   // Stop offering requests and wait until every response has come back.
   task automatic wait_until_idle();
      req_tvalid <= 1'b0;
      while (expected_averages.size() != 0) @(posedge clock);
   endtask

   // Write both window registers while the block is idle.
   task automatic set_windows(logic [WINDOW_W-1:0] short_value, logic [WINDOW_W-1:0] long_value);
      wait_until_idle();
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= SHORT_WINDOW_IDX;
      csr_wdata <= short_value;
      @(posedge clock);
      csr_index <= LONG_WINDOW_IDX;
      csr_wdata <= long_value;
      @(posedge clock);
      csr_we <= 1'b0;
      short_window_reg = short_value;
      long_window_reg = long_value;
   endtask

   // Warm-up under the reset windows, with the extremes of the sample range.
   task automatic test_warmup_extremes();
      send_sample(24'sh7FFFFF);
      send_sample(24'sh800000);
      send_sample(-24'sd1);
      send_sample(24'sd1);
      send_sample(24'sd0);
   endtask

   // Small windows, a rise, a fall, a rise again and a flat stretch that ties.
   task automatic test_directed_crosses();
      int levels [17] = '{100, 200, 300, 400, 500, 400, 300, 200, 100,
                          200, 300, 400, 400, 400, 400, 400, 500};
      set_windows(7'd2, 7'd4);
      foreach (levels[i]) send_sample(sample_t'(levels[i]));
   endtask

   // Random segments: ramps of random slope, flat runs, full-range noise,
   // extreme values and small noise around the current level.
   task automatic test_random_trends(logic [WINDOW_W-1:0] short_value,
                                     logic [WINDOW_W-1:0] long_value, int count);
      int sent;
      int kind;
      int len;
      int level;
      int step;
      sample_t sample;
      sent = 0;
      level = int'($urandom_range(24'hFFFFFF)) - 8388608;
      set_windows(short_value, long_value);
      while (sent < count) begin
         kind = $urandom_range(9);
         len = $urandom_range(3, 80);
         step = int'($urandom_range(131072)) - 65536;
         for (int i = 0; i < len && sent < count; i++) begin
            if (kind <= 5) level += step;
            else if (kind == 9) level += int'($urandom_range(512)) - 256;
            if (level > 8388607) level = 8388607;
            if (level < -8388608) level = -8388608;
            case (kind)
               7: sample = sample_t'($urandom_range(24'hFFFFFF));
               8: begin
                  case ($urandom_range(3))
                     0: sample = 24'sh7FFFFF;
                     1: sample = 24'sh800000;
                     2: sample = 24'sd0;
                     default: sample = -24'sd1;
                  endcase
               end
               default: sample = sample_t'(level);
            endcase
            send_sample(sample);
            sent++;
         end
      end
   endtask

   // Hold the response side off long enough that the block stalls its input.
   task automatic test_output_backpressure();
      wait_until_idle();
      @(posedge clock);
      hold_off_requests <= hold_off_requests + 1;
      for (int i = 0; i < 12; i++) send_sample(sample_t'($urandom_range(24'hFFFFFF)));
   endtask

   // Response side: random idling, or a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_off_requests != hold_off_taken) begin
         hold_off_taken <= hold_off_requests;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      crossover_result_t want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_averages.size() == 0) begin
            report_mismatch("unexpected_response", 24'h0, rsp_tdata[23:0]);
         end else begin
            want = expected_averages.pop_front();
            check_field("short_sma", want.short_sma, rsp_tdata[23:0]);
            check_field("long_sma", want.long_sma, rsp_tdata[47:24]);
            check_field("short_wma", want.short_wma, rsp_tdata[71:48]);
            check_field("long_wma", want.long_wma, rsp_tdata[95:72]);
            check_field("averages_ready", 24'(want.ready), 24'(rsp_tdata[RSP_READY_BIT]));
            check_field("sma_golden", 24'(want.sma_golden), 24'(rsp_tdata[RSP_SMA_GOLDEN_BIT]));
            check_field("sma_dead", 24'(want.sma_dead), 24'(rsp_tdata[RSP_SMA_DEAD_BIT]));
            check_field("wma_golden", 24'(want.wma_golden), 24'(rsp_tdata[RSP_WMA_GOLDEN_BIT]));
            check_field("wma_dead", 24'(want.wma_dead), 24'(rsp_tdata[RSP_WMA_DEAD_BIT]));
         end
         responses_checked++;
      end
   end

   // Test sequence.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 37;
      recv_idle_pct = 53;
      test_warmup_extremes();
      test_directed_crosses();
      test_random_trends(7'd0, 7'd127, 100);
      test_random_trends(7'd64, 7'd1, 90);

      send_idle_pct = 53;
      recv_idle_pct = 37;
      test_random_trends(7'd3, 7'd17, 100);
      test_random_trends(7'd20, 7'd20, 50);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_trends(7'd7, 7'd30, 100);
      test_output_backpressure();

      wait_until_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d responses, %0d SMA and %0d WMA crosses predicted.",
               responses_checked, sma_crosses, wma_crosses);
      $display("Windows ran from 1 to 64, out-of-range register values and a long output stall.");
      if (error_count == 0) begin
         $display("moving_average_crossover verification clean");
      end else begin
         $display("moving_average_crossover verification failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #8_000_000;
      $display("moving_average_crossover verification failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/mac_pkg.sv
hdl/mac_ram.sv
hdl/mac_div.sv
hdl/moving_average_crossover.sv
hdl/mac_checker.sv
bench/testbench.sv
